// File: rtl/ptl_pkg.sv
// Shared types, constants and helpers for the poptrie prefix lookup core.
// Used by the front end, the command queue, the trie walker and the top level.
package ptl_pkg;

  // Store depths; both must be powers of two so that the index wraps by truncation
  localparam int NODE_ENTRIES = 4096;
  localparam int LEAF_ENTRIES = 8192;

  // Trie geometry
  localparam int STRIDE  = 4;
  localparam int ADDR_W  = 32;
  localparam int LEVELS  = ADDR_W / STRIDE;
  localparam int FAN     = 1 << STRIDE;
  localparam int CNT_W   = $clog2(FAN + 1);
  localparam int LVL_W   = $clog2(LEVELS);

  // Store address widths and the width used for index sums before wrapping
  localparam int NODE_AW = $clog2(NODE_ENTRIES);
  localparam int LEAF_AW = $clog2(LEAF_ENTRIES);
  localparam int IDX_W   = 21;

  // Field widths of a transfer
  localparam int FUNC_W       = 2;
  localparam int ENTRY_W      = 13;
  localparam int LEAF_BASE_W  = 13;
  localparam int CHILD_BASE_W = 12;
  localparam int LEN_W        = 6;

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  // Function codes on the func port
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NODE_WR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LEAF_WR = 2'd2;

  // Operation carried through the queue
  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_NODE_WR,
    OP_LEAF_WR
  } op_t;

  // One node word as held in the node store
  typedef struct packed {
    logic [FAN-1:0]          child_bitmap;
    logic [FAN-1:0]          leaf_bitmap;
    logic [LEAF_BASE_W-1:0]  leaf_base;
    logic [CHILD_BASE_W-1:0] child_base;
  } node_word_t;

  localparam int NODE_W = $bits(node_word_t);

  // Classified command between front end and walker
  typedef struct packed {
    op_t                op;
    logic [ENTRY_W-1:0] entry_index;
    logic [ADDR_W-1:0]  ip_addr;
    node_word_t         node;
    logic [LEN_W-1:0]   leaf_length;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Walker states
  typedef enum logic [1:0] {
    S_IDLE,
    S_NODE,
    S_FIN
  } walk_state_t;

  // Count the set bits of one bitmap
  function automatic logic [CNT_W-1:0] popcount(input logic [FAN-1:0] x);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < FAN; i++) begin
      n = n + CNT_W'(x[i]);
    end
    return n;
  endfunction

endpackage

// File: rtl/ptl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ptl_queue.sv
// Short command queue between the front end and the trie walker.
// Depends on ptl_pkg for the command type and queue depth.
module ptl_queue
  import ptl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_data,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t            slot [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  // Store a pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (Q_AW + 1)'(1);
        2'b01:   count <= count - (Q_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  assign head       = slot[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (Q_AW + 1)'(QUEUE_DEPTH));

endmodule

// File: rtl/ptl_front.sv
// Front end: takes command transfers, classifies them and queues them.
// Depends on ptl_pkg for function codes and the command type.
module ptl_front
  import ptl_pkg::*;
(
  input  logic                    start,
  output logic                    busy,
  input  logic [FUNC_W-1:0]       func,
  input  logic [ENTRY_W-1:0]      entry_index,
  input  logic [ADDR_W-1:0]       ip_addr,
  input  logic [FAN-1:0]          child_bitmap,
  input  logic [FAN-1:0]          leaf_bitmap,
  input  logic [LEAF_BASE_W-1:0]  leaf_base,
  input  logic [CHILD_BASE_W-1:0] child_base,
  input  logic [LEN_W-1:0]        leaf_length,
  input  q_stat_t                 stat,
  output logic                    push,
  output cmd_t                    push_data
);

  logic known;
  op_t  op;

  // Decode the function code; drop the spare code
  always_comb begin
    known = 1'b1;
    op    = OP_LOOKUP;
    unique case (func)
      FUNC_LOOKUP:  op = OP_LOOKUP;
      FUNC_NODE_WR: op = OP_NODE_WR;
      FUNC_LEAF_WR: op = OP_LEAF_WR;
      default:      known = 1'b0;
    endcase
  end

  // Hold off new transfers while the queue is full
  assign busy = stat.full;
  assign push = start && !busy && known;

  // Pack the command
  always_comb begin
    push_data.op                = op;
    push_data.entry_index       = entry_index;
    push_data.ip_addr           = ip_addr;
    push_data.node.child_bitmap = child_bitmap;
    push_data.node.leaf_bitmap  = leaf_bitmap;
    push_data.node.leaf_base    = leaf_base;
    push_data.node.child_base   = child_base;
    push_data.leaf_length       = leaf_length;
  end

endmodule

// File: rtl/ptl_walk.sv
// Back end: executes store writes and walks the trie for lookups.
// Depends on ptl_pkg and instantiates ptl_ram for the node and leaf stores.
module ptl_walk
  import ptl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  q_stat_t          stat,
  input  cmd_t             head,
  output logic             pop,
  output logic             done,
  output logic [LEN_W-1:0] match_length
);

  walk_state_t state;
  walk_state_t state_next;

  logic [LVL_W-1:0]  level;
  logic [ADDR_W-1:0] addr_sh;
  logic [LEN_W-1:0]  result;
  logic              leaf_pend;

  logic               node_we;
  logic [NODE_AW-1:0] node_waddr;
  logic [NODE_AW-1:0] node_raddr;
  logic [NODE_W-1:0]  node_rdata;
  node_word_t         node;

  logic               leaf_we;
  logic [LEAF_AW-1:0] leaf_waddr;
  logic [LEAF_AW-1:0] leaf_raddr;
  logic [LEN_W-1:0]   leaf_rdata;

  logic [STRIDE-1:0] chunk;
  logic [FAN-1:0]    upto;
  logic              leaf_hit;
  logic              child_hit;
  logic              last_level;
  logic [IDX_W-1:0]  leaf_sum;
  logic [IDX_W-1:0]  child_sum;

  // Node and leaf stores
  ptl_ram #(.WIDTH(NODE_W), .DEPTH(NODE_ENTRIES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (head.node),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  ptl_ram #(.WIDTH(LEN_W), .DEPTH(LEAF_ENTRIES)) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (head.leaf_length),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  assign node = node_word_t'(node_rdata);

  // Evaluate the node word read for the current level
  always_comb begin
    chunk = addr_sh[ADDR_W-1 -: STRIDE];
    for (int i = 0; i < FAN; i++) begin
      upto[i] = (STRIDE'(i) <= chunk);
    end
    leaf_hit   = node.leaf_bitmap[chunk];
    child_hit  = node.child_bitmap[chunk];
    last_level = (level == LVL_W'(LEVELS - 1));
    leaf_sum   = IDX_W'(node.leaf_base) + IDX_W'(popcount(node.leaf_bitmap & upto))
                 - IDX_W'(1);
    child_sum  = IDX_W'(node.child_base) + IDX_W'(popcount(node.child_bitmap & upto))
                 - IDX_W'(1);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!stat.empty && head.op == OP_LOOKUP) begin
          state_next = S_NODE;
        end
      end
      S_NODE: begin
        if (!(child_hit && !last_level)) begin
          state_next = S_FIN;
        end
      end
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Store ports and queue pop
  always_comb begin
    pop        = (state == S_IDLE) && !stat.empty;
    node_we    = pop && (head.op == OP_NODE_WR);
    leaf_we    = pop && (head.op == OP_LEAF_WR);
    node_waddr = head.entry_index[NODE_AW-1:0];
    leaf_waddr = head.entry_index[LEAF_AW-1:0];
    node_raddr = (state == S_IDLE) ? '0 : child_sum[NODE_AW-1:0];
    leaf_raddr = leaf_sum[LEAF_AW-1:0];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk registers and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_pend <= 1'b0;
      done      <= 1'b0;
      level     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          level     <= '0;
          addr_sh   <= head.ip_addr;
          result    <= '0;
          leaf_pend <= 1'b0;
        end
        S_NODE: begin
          if (leaf_pend) begin
            result <= leaf_rdata;
          end
          leaf_pend <= leaf_hit;
          level     <= level + LVL_W'(1);
          addr_sh   <= addr_sh << STRIDE;
        end
        S_FIN: begin
          done         <= 1'b1;
          match_length <= leaf_pend ? leaf_rdata : result;
          leaf_pend    <= 1'b0;
        end
        default: begin
          leaf_pend <= 1'b0;
        end
      endcase
    end
  end

  // A result strobe always follows the final step of a walk
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> done)
    else $error("walk finished without a result strobe");

  // A result strobe never appears without a finished walk
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_FIN))
    else $error("result strobe without a finished walk");

  // A pending leaf read only exists inside a walk
  a_leaf_pend: assert property (@(posedge clk) disable iff (rst)
    leaf_pend |-> (state == S_NODE || state == S_FIN))
    else $error("leaf read pending outside a walk");

  // A walk step follows either the start of a walk or another step
  a_node_src: assert property (@(posedge clk) disable iff (rst)
    (state == S_NODE) |-> ($past(state) == S_IDLE || $past(state) == S_NODE))
    else $error("walk step entered from the wrong state");

endmodule

// File: rtl/poptrie_prefix_lookup_core.sv
// Poptrie longest-prefix lookup core: top level.
// Depends on ptl_pkg; instantiates ptl_front, ptl_queue and ptl_walk.
//
// Commands are transferred when start is high and busy is low; func selects
// a lookup, a node store write or a leaf store write (the spare code is
// dropped). Commands pass through a two-entry queue to the trie walker and
// are executed strictly in order, so a lookup sees every earlier write. A
// store write is done as the walker pops it. A lookup passes through a start
// step, a walk step for each trie level visited (1 to 8) and a final step: each
// level needs one registered node store read before its popcount can choose
// the next node, and this per-level node read sets the lookup time. busy is
// high only while the queue is full. Each lookup gives exactly one result:
// done is high for one cycle with match_length valid, and the receiver cannot
// stall it. Both stores come up undefined and have no clearing pass; load
// every entry a lookup can reach before looking up.
module poptrie_prefix_lookup_core
  import ptl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [FUNC_W-1:0]       func,
  input  logic [ENTRY_W-1:0]      entry_index,
  input  logic [ADDR_W-1:0]       ip_addr,
  input  logic [FAN-1:0]          child_bitmap,
  input  logic [FAN-1:0]          leaf_bitmap,
  input  logic [LEAF_BASE_W-1:0]  leaf_base,
  input  logic [CHILD_BASE_W-1:0] child_base,
  input  logic [LEN_W-1:0]        leaf_length,
  output logic                    done,
  output logic [LEN_W-1:0]        match_length
);

  logic    push;
  logic    pop;
  cmd_t    push_data;
  cmd_t    head;
  q_stat_t stat;

  // Accept and classify command transfers
  ptl_front u_front (
    .start        (start),
    .busy         (busy),
    .func         (func),
    .entry_index  (entry_index),
    .ip_addr      (ip_addr),
    .child_bitmap (child_bitmap),
    .leaf_bitmap  (leaf_bitmap),
    .leaf_base    (leaf_base),
    .child_base   (child_base),
    .leaf_length  (leaf_length),
    .stat         (stat),
    .push         (push),
    .push_data    (push_data)
  );

  // Decouple front end from walker
  ptl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  // Execute writes and walk the trie
  ptl_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .stat         (stat),
    .head         (head),
    .pop          (pop),
    .done         (done),
    .match_length (match_length)
  );

endmodule

// File: test/tb_poptrie_prefix_lookup_core.sv
// Self-checking testbench for poptrie_prefix_lookup_core: builds tries on demand,
// looks addresses up and checks every match length against a shadow of both stores.
// Depends on ptl_pkg and the poptrie_prefix_lookup_core RTL.
module tb_poptrie_prefix_lookup_core;
  import ptl_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int ITEM_TARGET  = 1300;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [ENTRY_W-1:0] entry_index;
    logic [ADDR_W-1:0]  ip_addr;
    node_word_t         node;
    logic [LEN_W-1:0]   leaf_length;
  } cmd_item_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [FUNC_W-1:0]       func = FUNC_LOOKUP;
  logic [ENTRY_W-1:0]      entry_index = '0;
  logic [ADDR_W-1:0]       ip_addr = '0;
  logic [FAN-1:0]          child_bitmap = '0;
  logic [FAN-1:0]          leaf_bitmap = '0;
  logic [LEAF_BASE_W-1:0]  leaf_base = '0;
  logic [CHILD_BASE_W-1:0] child_base = '0;
  logic [LEN_W-1:0]        leaf_length = '0;
  logic                    done;
  logic [LEN_W-1:0]        match_length;

  // Commands waiting to be driven and match lengths waiting to come back
  cmd_item_t        cmd_backlog[$];
  logic [LEN_W-1:0] due_lengths[$];

  // Shadow of the stores as the block holds them after each accepted transfer
  node_word_t       node_mem[0:NODE_ENTRIES-1];
  logic [LEN_W-1:0] leaf_mem[0:LEAF_ENTRIES-1];

  // Stimulus-side view of the stores: used to load every entry a lookup reaches
  node_word_t plan_node[0:NODE_ENTRIES-1];
  bit         plan_node_ok[0:NODE_ENTRIES-1];
  bit         plan_leaf_ok[0:LEAF_ENTRIES-1];

  int  queued_total = 0;
  int  counted = 0;
  int  accepted = 0;
  int  err_count = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  burst_left = 0;
  logic took = 1'b0;
  logic [ADDR_W-1:0] last_addr = '0;

  poptrie_prefix_lookup_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .entry_index  (entry_index),
    .ip_addr      (ip_addr),
    .child_bitmap (child_bitmap),
    .leaf_bitmap  (leaf_bitmap),
    .leaf_base    (leaf_base),
    .child_base   (child_base),
    .leaf_length  (leaf_length),
    .done         (done),
    .match_length (match_length)
  );

  always #5 clk = ~clk;

  // Longest matching prefix length for one address over the shadow stores
  function automatic logic [LEN_W-1:0] longest_match(logic [ADDR_W-1:0] addr);
    logic [NODE_AW-1:0] at;
    logic [LEN_W-1:0]   found;
    logic [STRIDE-1:0]  nib;
    logic [FAN-1:0]     upto;
    node_word_t         w;
    at = '0;
    found = '0;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      w = node_mem[at];
      nib = addr[ADDR_W-1-STRIDE*lvl -: STRIDE];
      upto = FAN'((32'd2 << nib) - 1);
      if (w.leaf_bitmap[nib]) begin
        found = leaf_mem[LEAF_AW'(w.leaf_base + $countones(w.leaf_bitmap & upto) - 1)];
      end
      if (!w.child_bitmap[nib]) break;
      at = NODE_AW'(w.child_base + $countones(w.child_bitmap & upto) - 1);
    end
    return found;
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t it;
    it.func = FUNC_LOOKUP;
    it.entry_index = ENTRY_W'($urandom);
    it.ip_addr = $urandom;
    it.node = node_word_t'(NODE_W'({$urandom, $urandom}));
    it.leaf_length = LEN_W'($urandom_range(0, 32));
    return it;
  endfunction

  // Mostly random bitmaps, biased dense so that walks often go deep
  function automatic logic [FAN-1:0] random_bitmap();
    int unsigned mode;
    logic [FAN-1:0] a, b;
    mode = $urandom_range(0, 9);
    a = FAN'($urandom);
    b = FAN'($urandom);
    case (mode)
      0, 1, 2: return a;
      3, 4, 5: return a | b;
      6:       return a & b;
      7:       return '1;
      8:       return a | b | FAN'($urandom);
      default: return '0;
    endcase
  endfunction

  function automatic node_word_t random_node();
    node_word_t w;
    w.child_bitmap = random_bitmap();
    w.leaf_bitmap = random_bitmap();
    w.leaf_base = LEAF_BASE_W'($urandom);
    w.child_base = CHILD_BASE_W'($urandom);
    return w;
  endfunction

  function automatic node_word_t make_node(logic [FAN-1:0] cb, logic [FAN-1:0] lb,
                                           int lbase, int cbase);
    node_word_t w;
    w.child_bitmap = cb;
    w.leaf_bitmap = lb;
    w.leaf_base = LEAF_BASE_W'(lbase);
    w.child_base = CHILD_BASE_W'(cbase);
    return w;
  endfunction

  // Gap after a transfer: mostly none or short, a few long, with idle-free bursts
  function automatic int next_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic enqueue(cmd_item_t it);
    cmd_backlog.push_back(it);
    queued_total++;
    if (it.func != FUNC_SPARE) counted++;
  endtask

  task automatic push_node(logic [ENTRY_W-1:0] idx, node_word_t w);
    cmd_item_t it;
    it = random_item();
    it.func = FUNC_NODE_WR;
    it.entry_index = idx;
    it.node = w;
    plan_node[idx[NODE_AW-1:0]] = w;
    plan_node_ok[idx[NODE_AW-1:0]] = 1'b1;
    enqueue(it);
  endtask

  task automatic push_leaf(logic [ENTRY_W-1:0] idx, logic [LEN_W-1:0] len);
    cmd_item_t it;
    it = random_item();
    it.func = FUNC_LEAF_WR;
    it.entry_index = idx;
    it.leaf_length = len;
    plan_leaf_ok[idx[LEAF_AW-1:0]] = 1'b1;
    enqueue(it);
  endtask

  task automatic push_noise();
    cmd_item_t it;
    it = random_item();
    it.func = FUNC_SPARE;
    enqueue(it);
  endtask

  // Load every node and leaf the walk will touch, then queue the lookup
  task automatic push_lookup(logic [ADDR_W-1:0] addr);
    logic [NODE_AW-1:0] at;
    logic [LEAF_AW-1:0] li;
    logic [STRIDE-1:0]  nib;
    logic [FAN-1:0]     upto;
    node_word_t         w;
    cmd_item_t          it;
    at = '0;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      if (!plan_node_ok[at]) push_node({1'($urandom), at}, random_node());
      w = plan_node[at];
      nib = addr[ADDR_W-1-STRIDE*lvl -: STRIDE];
      upto = FAN'((32'd2 << nib) - 1);
      if (w.leaf_bitmap[nib]) begin
        li = LEAF_AW'(w.leaf_base + $countones(w.leaf_bitmap & upto) - 1);
        if (!plan_leaf_ok[li]) push_leaf(li, LEN_W'($urandom_range(0, 32)));
      end
      if (!w.child_bitmap[nib]) break;
      at = NODE_AW'(w.child_base + $countones(w.child_bitmap & upto) - 1);
    end
    it = random_item();
    it.func = FUNC_LOOKUP;
    it.ip_addr = addr;
    last_addr = addr;
    enqueue(it);
  endtask

  task automatic report_error(string msg);
    if (err_count < REPORT_MAX) $display("mismatch: %s", msg);
    err_count++;
  endtask

  // Present the next command at the falling edge; hold it until it transfers
  always @(negedge clk) begin : drive_step
    cmd_item_t it;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !took)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        it = cmd_backlog.pop_front();
        func <= it.func;
        entry_index <= it.entry_index;
        ip_addr <= it.ip_addr;
        child_bitmap <= it.node.child_bitmap;
        leaf_bitmap <= it.node.leaf_bitmap;
        leaf_base <= it.node.leaf_base;
        child_base <= it.node.child_base;
        leaf_length <= it.leaf_length;
        gap_left <= next_gap();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check result strobes and fold accepted transfers into the shadow stores
  always @(posedge clk) begin : watch_step
    logic xfer;
    logic [LEN_W-1:0] want;
    if (rst) begin
      took <= 1'b0;
    end else begin
      xfer = start && (busy === 1'b0);
      took <= xfer;
      if (done === 1'b1) begin
        if (due_lengths.size() == 0) begin
          report_error($sformatf("match_length %0d with no lookup outstanding", match_length));
        end else begin
          want = due_lengths.pop_front();
          if (match_length !== want) begin
            report_error($sformatf("match_length expected %0d, got %0d", want, match_length));
          end
        end
      end
      if (xfer) begin
        accepted <= accepted + 1;
        case (func)
          FUNC_NODE_WR: begin
            node_mem[entry_index[NODE_AW-1:0]] =
              {child_bitmap, leaf_bitmap, leaf_base, child_base};
          end
          FUNC_LEAF_WR: begin
            leaf_mem[entry_index[LEAF_AW-1:0]] = leaf_length;
          end
          FUNC_LOOKUP: begin
            due_lengths.push_back(longest_match(ip_addr));
          end
          default: ;
        endcase
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_poptrie_prefix_lookup_core: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    // Spare code first: must be dropped without a result
    push_noise();
    // Root with every bit set, written through an aliased index: walk loops on node 0
    push_node(13'h1000, make_node('1, '1, 0, 0));
    push_leaf(13'd0, 6'd32);
    push_lookup(32'h0000_0000);
    // Leaf at the top level only, child without matches below it
    push_leaf(13'd15, 6'd7);
    push_node(13'd15, make_node('0, '0, 0, 0));
    push_lookup(32'hFFFF_FFFF);
    // Leaf index wraps past the end of the leaf store
    push_leaf(13'd1, 6'd4);
    push_node(13'd1, make_node('0, '1, 8191, 4095));
    push_leaf(13'd8191, 6'd1);
    push_lookup(32'h1000_0000);
    push_lookup(32'h1100_0000);
    // Child index wraps past the end of the node store; no leaves anywhere
    push_node(13'd0, make_node('1, '0, 0, 4095));
    push_node(13'd4095, make_node('0, '0, 0, 0));
    push_lookup(32'h0FFF_FFFF);
    push_lookup(32'h1111_1111);
    push_leaf(13'd8191, 6'd32);
    push_leaf(13'h1555, 6'd0);
    push_lookup(32'h8000_0001);
    push_noise();

    // Random part: mostly lookups over tries grown on demand, some rewrites and noise
    while (counted < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        push_noise();
      end else if (pick < 14) begin
        push_node(ENTRY_W'($urandom), random_node());
      end else if (pick < 24) begin
        push_leaf(ENTRY_W'($urandom), LEN_W'($urandom_range(0, 32)));
      end else if (pick < 60) begin
        push_lookup($urandom);
      end else begin
        push_lookup(last_addr ^ (32'($urandom) >> $urandom_range(4, 31)));
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: all commands transferred, all lengths back, then let the walker settle
    while (accepted != queued_total) @(negedge clk);
    while (due_lengths.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_poptrie_prefix_lookup_core: done, clean");
    end else begin
      $display("tb_poptrie_prefix_lookup_core: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ptl_pkg.sv
rtl/ptl_ram.sv
rtl/ptl_queue.sv
rtl/ptl_front.sv
rtl/ptl_walk.sv
rtl/poptrie_prefix_lookup_core.sv
test/tb_poptrie_prefix_lookup_core.sv
